// File: design/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg
// Command codes, status codes and pipeline control word for the quaternion ALU.
// ----------------------------------------------------------------------------
package qalu_pkg;

  // command codes carried by in_cmd
  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_PROD  = 3'd2,
    CMD_CONJ  = 3'd3,
    CMD_SCALE = 3'd4,
    CMD_DIV   = 3'd5,
    CMD_NORM  = 3'd6
  } cmd_t;

  // status codes reported with each result word
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // control that travels down the pipeline with each word
  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic dz;
  } ctl_t;

endpackage

// File: design/quaternion_alu.sv
// ----------------------------------------------------------------------------
// quaternion_alu
// Throughput: one command per cycle; busy is always low and the result strobe
// cannot be held off. The depth is set by the divider, one quotient bit per stage.
// Reset (synchronous, rst_n low) clears the valid bits of every stage.
// Fixed-point quaternion add, sub, Hamilton product, conjugate, scale, divide
// and squared norm with saturation.
// ----------------------------------------------------------------------------
module quaternion_alu #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_cmd,
  input  logic signed [WORD_BITS-1:0] in_a_x,
  input  logic signed [WORD_BITS-1:0] in_a_y,
  input  logic signed [WORD_BITS-1:0] in_a_z,
  input  logic signed [WORD_BITS-1:0] in_a_w,
  input  logic signed [WORD_BITS-1:0] in_b_x,
  input  logic signed [WORD_BITS-1:0] in_b_y,
  input  logic signed [WORD_BITS-1:0] in_b_z,
  input  logic signed [WORD_BITS-1:0] in_b_w,
  input  logic signed [WORD_BITS-1:0] in_scalar,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_r_x,
  output logic signed [WORD_BITS-1:0] out_r_y,
  output logic signed [WORD_BITS-1:0] out_r_z,
  output logic signed [WORD_BITS-1:0] out_r_w,
  output logic [1:0]                  out_status
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;
  localparam int NW = W + F;
  localparam int L  = NW + 2;

  localparam logic signed [SW-1:0] HI_SW = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] LO_SW = -(SW'(1) << (W - 1));
  localparam logic signed [SW-1:0] HALF  = SW'(1) << (F - 1);
  localparam logic [NW:0] QMAX = ((NW + 1)'(1) << (W - 1)) - (NW + 1)'(1);
  localparam logic [NW:0] QMIN = (NW + 1)'(1) << (W - 1);

  // clamp to the word range, msb of the result is the saturation flag
  function automatic logic [W:0] clamp_fn(input logic signed [SW-1:0] v);
    logic [W:0] res;
    if (v > HI_SW) begin
      res = {1'b1, 1'b0, {(W-1){1'b1}}};
    end else if (v < LO_SW) begin
      res = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      res = {1'b0, v[W-1:0]};
    end
    return res;
  endfunction

  logic signed [W-1:0] a_v [4];
  logic signed [W-1:0] b_v [4];
  qalu_pkg::ctl_t      ctl_nxt;
  qalu_pkg::ctl_t      ctl_r [1:L-1];

  assign busy = 1'b0;

  // gather input word into lanes
  always_comb begin
    a_v[0] = in_a_x; a_v[1] = in_a_y; a_v[2] = in_a_z; a_v[3] = in_a_w;
    b_v[0] = in_b_x; b_v[1] = in_b_y; b_v[2] = in_b_z; b_v[3] = in_b_w;
    ctl_nxt.valid = start;
    ctl_nxt.cmd   = qalu_pkg::cmd_t'(in_cmd);
    ctl_nxt.dz    = (in_scalar == '0);
  end

  // control pipeline, only the valid bits are reset
  always_ff @(posedge clk) begin
    ctl_r[1].cmd <= ctl_nxt.cmd;
    ctl_r[1].dz  <= ctl_nxt.dz;
    for (int i = 2; i <= L - 1; i++) begin
      ctl_r[i].cmd <= ctl_r[i-1].cmd;
      ctl_r[i].dz  <= ctl_r[i-1].dz;
    end
    if (!rst_n) begin
      for (int i = 1; i <= L - 1; i++) ctl_r[i].valid <= 1'b0;
    end else begin
      ctl_r[1].valid <= ctl_nxt.valid;
      for (int i = 2; i <= L - 1; i++) ctl_r[i].valid <= ctl_r[i-1].valid;
    end
  end

  // ---------------- front path: add, sub, conj, product, scale, norm -------

  logic signed [PW-1:0] p_r  [4][4];
  logic signed [PW-1:0] sc_r [4];
  logic signed [PW-1:0] sq_r [4];
  logic signed [W:0]    as_nxt [4];
  logic signed [W:0]    as_r   [4];
  logic signed [W:0]    as2_r  [4];
  logic signed [SW-1:0] acc_nxt [4];
  logic signed [SW-1:0] acc_r   [4];
  logic [W:0]           fr_nxt  [4];
  logic [W-1:0]         fr_r [3:L-1][4];
  logic                 fsat_r [3:L-1];

  // add, sub and conjugate before clamping
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      case (ctl_nxt.cmd)
        qalu_pkg::CMD_ADD:  as_nxt[l] = (W+1)'(a_v[l]) + (W+1)'(b_v[l]);
        qalu_pkg::CMD_SUB:  as_nxt[l] = (W+1)'(a_v[l]) - (W+1)'(b_v[l]);
        qalu_pkg::CMD_CONJ: as_nxt[l] = (l == 3) ? (W+1)'(a_v[l]) : -(W+1)'(a_v[l]);
        default:            as_nxt[l] = '0;
      endcase
    end
  end

  // stage 1: multipliers
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) p_r[i][j] <= PW'(a_v[i]) * PW'(b_v[j]);
      sc_r[i] <= PW'(a_v[i]) * PW'(in_scalar);
      sq_r[i] <= PW'(a_v[i]) * PW'(a_v[i]);
      as_r[i] <= as_nxt[i];
    end
  end

  // stage 2: sums of products plus rounding half
  always_comb begin
    for (int l = 0; l < 4; l++) acc_nxt[l] = HALF;
    case (ctl_r[1].cmd)
      qalu_pkg::CMD_PROD: begin
        acc_nxt[0] = SW'(p_r[3][0]) + SW'(p_r[0][3]) + SW'(p_r[1][2]) - SW'(p_r[2][1]) + HALF;
        acc_nxt[1] = SW'(p_r[3][1]) + SW'(p_r[1][3]) + SW'(p_r[2][0]) - SW'(p_r[0][2]) + HALF;
        acc_nxt[2] = SW'(p_r[3][2]) + SW'(p_r[2][3]) + SW'(p_r[0][1]) - SW'(p_r[1][0]) + HALF;
        acc_nxt[3] = SW'(p_r[3][3]) - SW'(p_r[0][0]) - SW'(p_r[1][1]) - SW'(p_r[2][2]) + HALF;
      end
      qalu_pkg::CMD_SCALE: begin
        for (int l = 0; l < 4; l++) acc_nxt[l] = SW'(sc_r[l]) + HALF;
      end
      qalu_pkg::CMD_NORM: begin
        acc_nxt[0] = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]) + HALF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      acc_r[l] <= acc_nxt[l];
      as2_r[l] <= as_r[l];
    end
  end

  // stage 3: round, clamp and select
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      case (ctl_r[2].cmd)
        qalu_pkg::CMD_ADD, qalu_pkg::CMD_SUB, qalu_pkg::CMD_CONJ:
          fr_nxt[l] = clamp_fn(SW'(as2_r[l]));
        qalu_pkg::CMD_PROD, qalu_pkg::CMD_SCALE, qalu_pkg::CMD_NORM:
          fr_nxt[l] = clamp_fn(acc_r[l] >>> F);
        default:
          fr_nxt[l] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) fr_r[3][l] <= fr_nxt[l][W-1:0];
    fsat_r[3] <= fr_nxt[0][W] | fr_nxt[1][W] | fr_nxt[2][W] | fr_nxt[3][W];
    for (int i = 4; i <= L - 1; i++) begin
      for (int l = 0; l < 4; l++) fr_r[i][l] <= fr_r[i-1][l];
      fsat_r[i] <= fsat_r[i-1];
    end
  end

  // ---------------- divider: one quotient bit per stage --------------------

  logic [W-1:0]  drem_r [1:NW+1][4];
  logic [NW-1:0] dquo_r [1:NW+1][4];
  logic          dneg_r [1:NW+1][4];
  logic [W-1:0]  dus_r  [1:NW+1];
  logic [W:0]    sw_abs;
  logic [W:0]    aw_abs [4];

  // magnitudes and signs at entry
  always_comb begin
    sw_abs = in_scalar[W-1] ? -(W+1)'(in_scalar) : (W+1)'(in_scalar);
    for (int l = 0; l < 4; l++) begin
      aw_abs[l] = a_v[l][W-1] ? -(W+1)'(a_v[l]) : (W+1)'(a_v[l]);
    end
  end

  always_ff @(posedge clk) begin
    dus_r[1] <= sw_abs[W-1:0];
    for (int l = 0; l < 4; l++) begin
      drem_r[1][l] <= '0;
      dquo_r[1][l] <= {aw_abs[l][W-1:0], {F{1'b0}}};
      dneg_r[1][l] <= a_v[l][W-1] ^ in_scalar[W-1];
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_div
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [W:0] rsh;
      logic [W:0] dif;
      logic       ge;

      // shift in next numerator bit, trial subtract
      assign rsh = {drem_r[k][l], dquo_r[k][l][NW-1]};
      assign dif = rsh - {1'b0, dus_r[k]};
      assign ge  = (rsh >= {1'b0, dus_r[k]});

      always_ff @(posedge clk) begin
        drem_r[k+1][l] <= ge ? dif[W-1:0] : rsh[W-1:0];
        dquo_r[k+1][l] <= {dquo_r[k][l][NW-2:0], ge};
        dneg_r[k+1][l] <= dneg_r[k][l];
      end
    end

    always_ff @(posedge clk) begin
      dus_r[k+1] <= dus_r[k];
    end
  end

  // quotient rounding and saturation
  logic [NW:0]  dq1 [4];
  logic [NW:0]  dqn [4];
  logic [W-1:0] dres [4];
  logic [3:0]   dsat;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dq1[l] = {1'b0, dquo_r[NW+1][l]}
             + (({drem_r[NW+1][l], 1'b0} >= {1'b0, dus_r[NW+1]}) ? (NW+1)'(1) : '0);
      dqn[l] = (NW+1)'(0) - dq1[l];
      dsat[l] = 1'b0;
      if (!dneg_r[NW+1][l]) begin
        if (dq1[l] > QMAX) begin
          dsat[l] = 1'b1;
          dres[l] = {1'b0, {(W-1){1'b1}}};
        end else begin
          dres[l] = dq1[l][W-1:0];
        end
      end else begin
        if (dq1[l] > QMIN) begin
          dsat[l] = 1'b1;
          dres[l] = {1'b1, {(W-1){1'b0}}};
        end else begin
          dres[l] = dqn[l][W-1:0];
        end
      end
    end
  end

  // ---------------- output register ----------------------------------------

  logic         out_valid_r;
  logic [W-1:0] out_r_r [4];
  logic [1:0]   out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_r[L-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_r[L-1].cmd == qalu_pkg::CMD_DIV) begin
      if (ctl_r[L-1].dz) begin
        for (int l = 0; l < 4; l++) out_r_r[l] <= '0;
        out_status_r <= qalu_pkg::ST_DZ;
      end else begin
        for (int l = 0; l < 4; l++) out_r_r[l] <= dres[l];
        out_status_r <= (|dsat) ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
      end
    end else begin
      for (int l = 0; l < 4; l++) out_r_r[l] <= fr_r[L-1][l];
      out_status_r <= fsat_r[L-1] ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_r_x    = out_r_r[0];
  assign out_r_y    = out_r_r[1];
  assign out_r_z    = out_r_r[2];
  assign out_r_w    = out_r_r[3];
  assign out_status = out_status_r;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_alu. Directed words cover saturation
// bounds, every command, conjugate of the most negative value, divide by
// zero and the undefined command; random words follow under several sender
// idle mixes. Each result word is compared against a software prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WB = 16;
  localparam int FB = 12;
  localparam int LATENCY = WB + FB + 2;
  localparam int WDOG_LIMIT = 2000;
  localparam logic [2:0] CMD_UNDEF = 3'd7;
  localparam longint WMAX = 32767;
  localparam longint WMIN = -32768;

  typedef struct packed {
    logic signed [WB-1:0] x, y, z, w;
    logic [1:0] st;
  } qres_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_cmd = '0;
  logic signed [WB-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  logic signed [WB-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic signed [WB-1:0] in_scalar = '0;
  logic out_valid;
  logic signed [WB-1:0] out_r_x, out_r_y, out_r_z, out_r_w;
  logic [1:0] out_status;

  qres_t pending_q[$];
  int errors = 0;
  int idle_pct = 0;
  int wdog = 0;

  always #5 clk = ~clk;

  quaternion_alu #(.WORD_BITS(WB), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_a_w(in_a_w), .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_b_w(in_b_w), .in_scalar(in_scalar), .out_valid(out_valid),
    .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z), .out_r_w(out_r_w),
    .out_status(out_status)
  );

  // clamp to word range
  function automatic logic [WB-1:0] sat_word(longint v, ref bit sat);
    if (v > WMAX) begin
      sat = 1;
      return WMAX[WB-1:0];
    end
    if (v < WMIN) begin
      sat = 1;
      return WMIN[WB-1:0];
    end
    return v[WB-1:0];
  endfunction

  // round half up then clamp
  function automatic logic [WB-1:0] rnd_sat(longint v, ref bit sat);
    return sat_word((v + (longint'(1) << (FB - 1))) >>> FB, sat);
  endfunction

  // fixed-point divide, nearest with ties away from zero
  function automatic logic [WB-1:0] div_word(longint a, longint s, ref bit sat);
    longint ua, us, q, r;
    bit neg;
    ua = a < 0 ? -a : a;
    us = s < 0 ? -s : s;
    neg = (a < 0) != (s < 0);
    q = (ua << FB) / us;
    r = (ua << FB) % us;
    if (r >= us - r) q++;
    return sat_word(neg ? -q : q, sat);
  endfunction

  function automatic qres_t quat_result(logic [2:0] cmd, longint a[4], longint b[4],
                                        longint s);
    qres_t res;
    logic [WB-1:0] o[4];
    bit sat;
    bit dz;
    sat = 0;
    dz = 0;
    for (int i = 0; i < 4; i++) o[i] = '0;
    case (cmd)
      qalu_pkg::CMD_ADD: for (int i = 0; i < 4; i++) o[i] = sat_word(a[i] + b[i], sat);
      qalu_pkg::CMD_SUB: for (int i = 0; i < 4; i++) o[i] = sat_word(a[i] - b[i], sat);
      qalu_pkg::CMD_PROD: begin
        o[0] = rnd_sat(a[3]*b[0] + b[3]*a[0] + a[1]*b[2] - a[2]*b[1], sat);
        o[1] = rnd_sat(a[3]*b[1] + b[3]*a[1] + a[2]*b[0] - a[0]*b[2], sat);
        o[2] = rnd_sat(a[3]*b[2] + b[3]*a[2] + a[0]*b[1] - a[1]*b[0], sat);
        o[3] = rnd_sat(a[3]*b[3] - (a[0]*b[0] + a[1]*b[1] + a[2]*b[2]), sat);
      end
      qalu_pkg::CMD_CONJ: begin
        for (int i = 0; i < 3; i++) o[i] = sat_word(-a[i], sat);
        o[3] = a[3][WB-1:0];
      end
      qalu_pkg::CMD_SCALE: for (int i = 0; i < 4; i++) o[i] = rnd_sat(a[i] * s, sat);
      qalu_pkg::CMD_DIV: begin
        if (s == 0) dz = 1;
        else for (int i = 0; i < 4; i++) o[i] = div_word(a[i], s, sat);
      end
      qalu_pkg::CMD_NORM:
        o[0] = rnd_sat(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3], sat);
      default: ;
    endcase
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    res.w = o[3];
    res.st = dz ? qalu_pkg::ST_DZ : (sat ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK);
    return res;
  endfunction

  // send one word, with random idle cycles before it
  task automatic send_word(logic [2:0] cmd, logic [WB-1:0] a[4], logic [WB-1:0] b[4],
                           logic [WB-1:0] s);
    longint sa[4], sb[4];
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 4; i++) begin
      sa[i] = $signed(a[i]);
      sb[i] = $signed(b[i]);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_a_x <= a[0]; in_a_y <= a[1]; in_a_z <= a[2]; in_a_w <= a[3];
    in_b_x <= b[0]; in_b_y <= b[1]; in_b_z <= b[2]; in_b_w <= b[3];
    in_scalar <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(quat_result(cmd, sa, sb, $signed(s)));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WB-1:0] rand_val();
    case ($urandom_range(5))
      0: return WMAX[WB-1:0];
      1: return WMIN[WB-1:0];
      2: return WB'($urandom_range(8191)) - WB'(4096);
      3: return '0;
      default: return WB'($urandom);
    endcase
  endfunction

  // extremes and every command, including the special cases
  task automatic test_directed();
    logic [WB-1:0] mx[4], mn[4], z[4], one[4], mix[4];
    for (int i = 0; i < 4; i++) begin
      mx[i] = WMAX[WB-1:0];
      mn[i] = WMIN[WB-1:0];
      z[i] = '0;
      one[i] = 16'h1000;
      mix[i] = i[0] ? 16'h8000 : 16'h7fff;
    end
    idle_pct = 0;
    send_word(qalu_pkg::CMD_ADD, mx, mx, '0);
    send_word(qalu_pkg::CMD_ADD, mn, mn, '0);
    send_word(qalu_pkg::CMD_SUB, mx, mn, '0);
    send_word(qalu_pkg::CMD_SUB, mn, mx, '0);
    send_word(qalu_pkg::CMD_PROD, mx, mx, '0);
    send_word(qalu_pkg::CMD_PROD, mn, mn, '0);
    send_word(qalu_pkg::CMD_PROD, one, mix, '0);
    send_word(qalu_pkg::CMD_CONJ, mn, z, '0);
    send_word(qalu_pkg::CMD_CONJ, mx, z, '0);
    send_word(qalu_pkg::CMD_SCALE, mn, z, 16'h8000);
    send_word(qalu_pkg::CMD_SCALE, mix, z, 16'h7fff);
    send_word(qalu_pkg::CMD_SCALE, one, z, 16'h0001);
    send_word(qalu_pkg::CMD_DIV, mix, z, '0);
    send_word(qalu_pkg::CMD_DIV, mn, z, 16'hffff);
    send_word(qalu_pkg::CMD_DIV, mx, z, 16'h0001);
    send_word(qalu_pkg::CMD_DIV, one, z, 16'h3000);
    send_word(qalu_pkg::CMD_NORM, mn, z, '0);
    send_word(qalu_pkg::CMD_NORM, one, z, '0);
    send_word(qalu_pkg::CMD_NORM, z, z, '0);
    send_word(CMD_UNDEF, mix, mx, 16'h1234);
    drain_results();
  endtask

  // random words at a given sender idle rate
  task automatic test_random(int n, int pct);
    logic [WB-1:0] a[4], b[4];
    idle_pct = pct;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 4; i++) begin
        a[i] = rand_val();
        b[i] = rand_val();
      end
      send_word(3'($urandom_range(7)), a, b, rand_val());
    end
  endtask

  // result checker
  always @(posedge clk) begin
    qres_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word x=%0d st=%0d", $time, out_r_x, out_status);
        errors++;
      end else begin
        exp_res = pending_q.pop_front();
        if (out_r_x !== exp_res.x || out_r_y !== exp_res.y || out_r_z !== exp_res.z
            || out_r_w !== exp_res.w || out_status !== exp_res.st) begin
          $display("%0t: mismatch expected %0d %0d %0d %0d st=%0d actual %0d %0d %0d %0d st=%0d",
                   $time, exp_res.x, exp_res.y, exp_res.z, exp_res.w, exp_res.st,
                   out_r_x, out_r_y, out_r_z, out_r_w, out_status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted word and no result word
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 0);
    test_random(500, 67);
    drain_results();
    test_random(500, 38);
    test_random(500, 0);
    drain_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
design/qalu_pkg.sv
design/quaternion_alu.sv
tb/tb_top.sv
